### rtl/core/pat_pkg.sv
// Shared types, codes and helpers for the publication attempt tracker.
`default_nettype none
package pat_pkg;

  localparam int TAG_W         = 64;
  localparam int SEQ_W         = 32;
  localparam int CODE_W        = 3;
  localparam int COUNT_W       = 16;
  localparam int ITEM_DATA_W   = 232;
  localparam int RESULT_DATA_W = 8;
  localparam int CFG_INDEX_W   = 1;
  localparam int CFG_DATA_W    = 64;

  localparam logic [CFG_INDEX_W-1:0] CFG_BOUNDARY = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] CFG_HISTORY  = 1'b1;
  localparam logic [COUNT_W-1:0]     HISTORY_RESET = 16'd16;

  localparam logic OP_INSTALL    = 1'b0;
  localparam logic OP_TRANSITION = 1'b1;

  localparam logic [CODE_W-1:0] ST_NOT_PUB    = 3'd0;
  localparam logic [CODE_W-1:0] ST_IN_PROG    = 3'd1;
  localparam logic [CODE_W-1:0] ST_PUBLISHED  = 3'd2;
  localparam logic [CODE_W-1:0] ST_FAIL_RETRY = 3'd3;
  localparam logic [CODE_W-1:0] ST_FAIL_TERM  = 3'd4;
  localparam logic [CODE_W-1:0] ST_ACCEPTED   = 3'd5;

  localparam logic [CODE_W-1:0] STS_OK            = 3'd0;
  localparam logic [CODE_W-1:0] STS_WRONG_VIEW    = 3'd1;
  localparam logic [CODE_W-1:0] STS_WRONG_BOUND   = 3'd2;
  localparam logic [CODE_W-1:0] STS_HIST_FULL     = 3'd3;
  localparam logic [CODE_W-1:0] STS_BAD_MOVE      = 3'd4;
  localparam logic [CODE_W-1:0] STS_PRIOR_PENDING = 3'd5;

  typedef struct packed {
    logic               opcode;
    logic [SEQ_W-1:0]   attempt_seq;
    logic [TAG_W-1:0]   attempt_tag;
    logic [CODE_W-1:0]  to_state;
    logic [CODE_W-1:0]  from_state;
    logic [TAG_W-1:0]   boundary_in;
    logic [TAG_W-1:0]   view_tag;
  } pat_item_t;

  typedef struct packed {
    logic              view_visible;
    logic [CODE_W-1:0] state_out;
    logic [CODE_W-1:0] status;
  } pat_result_t;

  function automatic logic legal_move(input logic [CODE_W-1:0] from_s,
                                      input logic [CODE_W-1:0] to_s);
    logic ok;
    if (to_s == ST_IN_PROG) begin
      ok = (from_s == ST_NOT_PUB) || (from_s == ST_FAIL_RETRY);
    end else if (from_s == ST_IN_PROG) begin
      ok = (to_s == ST_PUBLISHED) || (to_s == ST_FAIL_RETRY) || (to_s == ST_FAIL_TERM);
    end else begin
      ok = (from_s == ST_PUBLISHED) && (to_s == ST_ACCEPTED);
    end
    return ok;
  endfunction

endpackage
`default_nettype wire

### rtl/core/pat_in_stage.sv
// Input register stage that holds one request until the core takes it.
`default_nettype none
module pat_in_stage (
  input  wire                      clk,
  input  wire                      rst,
  input  wire                      in_valid,
  output logic                     in_ready,
  input  wire pat_pkg::pat_item_t  in_item,
  input  wire                      advance,
  output logic                     valid,
  output pat_pkg::pat_item_t       item
);
  import pat_pkg::*;

  assign in_ready = !valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item <= in_item;
    end
  end

endmodule
`default_nettype wire

### rtl/core/pat_core.sv
// Lifecycle state registers and the single-pass request check.
`default_nettype none
module pat_core #(
  parameter int ID_WIDTH = 64
) (
  input  wire                          clk,
  input  wire                          rst,
  input  wire                          fire,
  input  wire pat_pkg::pat_item_t      item,
  input  wire [ID_WIDTH-1:0]           boundary_tag,
  input  wire [pat_pkg::COUNT_W-1:0]   history_limit,
  output pat_pkg::pat_result_t         result
);
  import pat_pkg::*;

  logic                view_present;
  logic [ID_WIDTH-1:0] current_view;
  logic [CODE_W-1:0]   pub_state;
  logic                attempt_present;
  logic [ID_WIDTH-1:0] active_attempt_tag;
  logic [SEQ_W-1:0]    active_attempt_seq;
  logic [COUNT_W-1:0]  transition_count;
  logic [CODE_W-1:0]   last_from;
  logic [CODE_W-1:0]   last_to;
  logic [ID_WIDTH-1:0] last_attempt_tag;
  logic [SEQ_W-1:0]    last_attempt_seq;

  logic [ID_WIDTH-1:0] vtag;
  logic [ID_WIDTH-1:0] btag;
  logic [ID_WIDTH-1:0] atag;
  logic                is_start;
  logic                repeat_hit;
  logic                start_ok;
  logic                cont_ok;
  logic                install_ok;
  logic                commit;
  logic [CODE_W-1:0]   status;
  logic [CODE_W-1:0]   pub_state_next;

  assign vtag = item.view_tag[ID_WIDTH-1:0];
  assign btag = item.boundary_in[ID_WIDTH-1:0];
  assign atag = item.attempt_tag[ID_WIDTH-1:0];
  assign is_start = (item.to_state == ST_IN_PROG);

  assign repeat_hit = (transition_count != '0) && (item.from_state == last_from) &&
                      (item.to_state == last_to) && (atag == last_attempt_tag) &&
                      (item.attempt_seq == last_attempt_seq);

  assign start_ok = (active_attempt_seq != '1) &&
                    (item.attempt_seq == active_attempt_seq + SEQ_W'(1)) &&
                    !((item.from_state == ST_FAIL_RETRY) && attempt_present &&
                      (atag == active_attempt_tag));

  assign cont_ok = attempt_present && (atag == active_attempt_tag) &&
                   (item.attempt_seq == active_attempt_seq);

  always_comb begin
    install_ok = 1'b0;
    commit     = 1'b0;
    if (item.opcode == OP_INSTALL) begin
      if (view_present && (pub_state != ST_ACCEPTED)) begin
        status = STS_PRIOR_PENDING;
      end else begin
        status     = STS_OK;
        install_ok = 1'b1;
      end
    end else begin
      priority if (!view_present || (vtag != current_view)) begin
        status = STS_WRONG_VIEW;
      end else if (btag != boundary_tag) begin
        status = STS_WRONG_BOUND;
      end else if (repeat_hit) begin
        status = STS_OK;
      end else if (transition_count >= history_limit) begin
        status = STS_HIST_FULL;
      end else if ((item.from_state != pub_state) ||
                   !legal_move(item.from_state, item.to_state)) begin
        status = STS_BAD_MOVE;
      end else if (is_start ? !start_ok : !cont_ok) begin
        status = STS_BAD_MOVE;
      end else begin
        status = STS_OK;
        commit = 1'b1;
      end
    end
  end

  always_comb begin
    priority if (install_ok) begin
      pub_state_next = ST_NOT_PUB;
    end else if (commit) begin
      pub_state_next = item.to_state;
    end else begin
      pub_state_next = pub_state;
    end
  end

  assign result.status       = status;
  assign result.state_out    = pub_state_next;
  assign result.view_visible = (pub_state_next == ST_PUBLISHED) ||
                               (pub_state_next == ST_ACCEPTED);

  always_ff @(posedge clk) begin
    if (rst) begin
      view_present       <= 1'b0;
      current_view       <= '0;
      pub_state          <= ST_NOT_PUB;
      attempt_present    <= 1'b0;
      active_attempt_tag <= '0;
      active_attempt_seq <= '0;
      transition_count   <= '0;
      last_from          <= ST_NOT_PUB;
      last_to            <= ST_NOT_PUB;
      last_attempt_tag   <= '0;
      last_attempt_seq   <= '0;
    end else if (fire) begin
      pub_state <= pub_state_next;
      if (install_ok) begin
        view_present       <= 1'b1;
        current_view       <= vtag;
        attempt_present    <= 1'b0;
        active_attempt_tag <= '0;
        active_attempt_seq <= '0;
        transition_count   <= '0;
        last_from          <= ST_NOT_PUB;
        last_to            <= ST_NOT_PUB;
        last_attempt_tag   <= '0;
        last_attempt_seq   <= '0;
      end else if (commit) begin
        if (is_start) begin
          attempt_present    <= 1'b1;
          active_attempt_tag <= atag;
          active_attempt_seq <= item.attempt_seq;
        end
        transition_count <= transition_count + COUNT_W'(1);
        last_from        <= item.from_state;
        last_to          <= item.to_state;
        last_attempt_tag <= atag;
        last_attempt_seq <= item.attempt_seq;
      end
    end
  end

`ifndef SYNTHESIS
  a_refuse_holds: assert property (@(posedge clk) disable iff (rst)
    fire && (status != STS_OK) |=> $stable(pub_state) && $stable(transition_count))
    else $error("refused request changed the lifecycle state");

  a_install_clears: assert property (@(posedge clk) disable iff (rst)
    fire && install_ok |=> (pub_state == ST_NOT_PUB) && (transition_count == '0) &&
                           !attempt_present)
    else $error("install did not clear the lifecycle state");

  a_no_attempt_idle: assert property (@(posedge clk) disable iff (rst)
    !attempt_present |-> (pub_state == ST_NOT_PUB))
    else $error("state advanced without an active attempt");
`endif

endmodule
`default_nettype wire

### rtl/core/publication_attempt_tracker_top.sv
// Top level: input stage, tracking core, configuration and result register.
// The request is registered in the input stage, then its result in the result register
// that drives m_tvalid; a stalled result holds the input stage.
// Throughput: one request per cycle while m_tready is high; the state registers in the core
// close their update loop as each request leaves the input stage.
// Reset (rst, synchronous): clears the lifecycle state, empties both stages,
// and returns boundary_tag to 0 and history_limit to 16.
`default_nettype none
module publication_attempt_tracker_top #(
  parameter int ID_WIDTH = 64
) (
  input  wire                                 clk,
  input  wire                                 rst,
  input  wire                                 s_tvalid,
  output logic                                s_tready,
  // view_tag[63:0], boundary_in[127:64], from_state[130:128], to_state[133:131],
  // attempt_tag[197:134], attempt_seq[229:198], zero pad[231:230]
  input  wire [pat_pkg::ITEM_DATA_W-1:0]      s_tdata,
  // opcode[0]
  input  wire                                 s_tuser,
  output logic                                m_tvalid,
  input  wire                                 m_tready,
  // status[2:0], state_out[5:3], view_visible[6], zero pad[7]
  output logic [pat_pkg::RESULT_DATA_W-1:0]   m_tdata,
  input  wire                                 cfg_wen,
  input  wire [pat_pkg::CFG_INDEX_W-1:0]      cfg_index,
  input  wire [pat_pkg::CFG_DATA_W-1:0]       cfg_wdata
);
  import pat_pkg::*;

  pat_item_t           s_item;
  pat_item_t           stage_item;
  logic                stage_valid;
  logic                advance;
  pat_result_t         core_result;
  pat_result_t         out_result;
  logic [ID_WIDTH-1:0] boundary_tag;
  logic [COUNT_W-1:0]  history_limit;

  assign s_item  = pat_item_t'({s_tuser, s_tdata[ITEM_DATA_W-3:0]});
  assign advance = stage_valid && (!m_tvalid || m_tready);

  pat_in_stage u_in_stage (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .in_item  (s_item),
    .advance  (advance),
    .valid    (stage_valid),
    .item     (stage_item)
  );

  pat_core #(
    .ID_WIDTH (ID_WIDTH)
  ) u_core (
    .clk           (clk),
    .rst           (rst),
    .fire          (advance),
    .item          (stage_item),
    .boundary_tag  (boundary_tag),
    .history_limit (history_limit),
    .result        (core_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      boundary_tag  <= '0;
      history_limit <= HISTORY_RESET;
    end else if (cfg_wen) begin
      unique case (cfg_index)
        CFG_BOUNDARY: boundary_tag  <= cfg_wdata[ID_WIDTH-1:0];
        CFG_HISTORY:  history_limit <= cfg_wdata[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_result <= core_result;
    end
  end

  assign m_tdata = {1'b0, out_result};

endmodule
`default_nettype wire

### test/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for the publication attempt tracker: predicts and checks each result.
module testbench;
  import pat_pkg::*;

  localparam int LONG_HOLD   = 120;
  localparam int PHASES      = 10;
  localparam int PHASE_ITEMS = 105;
  localparam logic [TAG_W-1:0] ONES = '1;

  typedef struct packed {
    logic              op;
    logic [TAG_W-1:0]  view;
    logic [TAG_W-1:0]  bound;
    logic [CODE_W-1:0] from_st;
    logic [CODE_W-1:0] to_st;
    logic [TAG_W-1:0]  tag;
    logic [SEQ_W-1:0]  seq;
  } request_t;

  typedef struct packed {
    logic [CODE_W-1:0] status;
    logic [CODE_W-1:0] state;
    logic              visible;
  } outcome_t;

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     s_tvalid = 1'b0;
  logic                     s_tready;
  logic [ITEM_DATA_W-1:0]   s_tdata = '0;
  logic                     s_tuser = 1'b0;
  logic                     m_tvalid;
  logic                     m_tready = 1'b0;
  logic [RESULT_DATA_W-1:0] m_tdata;
  logic                     cfg_wen = 1'b0;
  logic [CFG_INDEX_W-1:0]   cfg_index = '0;
  logic [CFG_DATA_W-1:0]    cfg_wdata = '0;

  publication_attempt_tracker_top uut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // tracker state and register copies
  logic [TAG_W-1:0]   boundary_reg = '0;
  logic [COUNT_W-1:0] limit_reg = HISTORY_RESET;
  logic               trk_present = 1'b0;
  logic [TAG_W-1:0]   trk_view = '0;
  logic [CODE_W-1:0]  trk_state = ST_NOT_PUB;
  logic               trk_attempt = 1'b0;
  logic [TAG_W-1:0]   trk_tag = '0;
  logic [SEQ_W-1:0]   trk_seq = '0;
  logic [COUNT_W-1:0] trk_count = '0;
  logic [CODE_W-1:0]  trk_last_from = '0;
  logic [CODE_W-1:0]  trk_last_to = '0;
  logic [TAG_W-1:0]   trk_last_tag = '0;
  logic [SEQ_W-1:0]   trk_last_seq = '0;

  // stimulus plan
  logic               plan_present;
  logic [TAG_W-1:0]   plan_view;
  logic [CODE_W-1:0]  plan_state;
  logic [TAG_W-1:0]   plan_tag;
  logic [SEQ_W-1:0]   plan_seq;
  logic               plan_has_last;
  request_t           plan_last;

  request_t request_q[$];
  outcome_t outcome_q[$];
  request_t offered;
  outcome_t predicted, want, got;
  int       requests_queued = 0;
  int       results_checked = 0;
  int       error_count = 0;
  int       send_gap = 0;
  int       stall_left = 0;
  int       hold_asked = 0;
  int       hold_served = 0;
  bit       sender_idle_en = 1'b1;
  bit       receiver_idle_en = 1'b1;

  function automatic logic move_allowed(input logic [CODE_W-1:0] f,
                                        input logic [CODE_W-1:0] t);
    case (f)
      ST_NOT_PUB:    return t == ST_IN_PROG;
      ST_IN_PROG:    return t == ST_PUBLISHED || t == ST_FAIL_RETRY || t == ST_FAIL_TERM;
      ST_PUBLISHED:  return t == ST_ACCEPTED;
      ST_FAIL_RETRY: return t == ST_IN_PROG;
      default:       return 1'b0;
    endcase
  endfunction

  task automatic track_request(input request_t r, output outcome_t o);
    logic [CODE_W-1:0] code;
    code = STS_OK;
    if (r.op == OP_INSTALL) begin
      if (trk_present && trk_state != ST_ACCEPTED) begin
        code = STS_PRIOR_PENDING;
      end else begin
        trk_present = 1'b1;
        trk_view = r.view;
        trk_state = ST_NOT_PUB;
        trk_attempt = 1'b0;
        trk_tag = '0;
        trk_seq = '0;
        trk_count = '0;
        trk_last_from = '0;
        trk_last_to = '0;
        trk_last_tag = '0;
        trk_last_seq = '0;
      end
    end else if (!trk_present || r.view != trk_view) begin
      code = STS_WRONG_VIEW;
    end else if (r.bound != boundary_reg) begin
      code = STS_WRONG_BOUND;
    end else if (trk_count != 0 && r.from_st == trk_last_from && r.to_st == trk_last_to &&
                 r.tag == trk_last_tag && r.seq == trk_last_seq) begin
      code = STS_OK;
    end else if (trk_count >= limit_reg) begin
      code = STS_HIST_FULL;
    end else if (r.from_st != trk_state || !move_allowed(r.from_st, r.to_st)) begin
      code = STS_BAD_MOVE;
    end else if (r.to_st == ST_IN_PROG && (trk_seq == '1 || r.seq != trk_seq + 32'd1)) begin
      code = STS_BAD_MOVE;
    end else if (r.to_st == ST_IN_PROG && r.from_st == ST_FAIL_RETRY && trk_attempt &&
                 r.tag == trk_tag) begin
      code = STS_BAD_MOVE;
    end else if (r.to_st != ST_IN_PROG &&
                 (!trk_attempt || r.tag != trk_tag || r.seq != trk_seq)) begin
      code = STS_BAD_MOVE;
    end else begin
      if (r.to_st == ST_IN_PROG) begin
        trk_attempt = 1'b1;
        trk_tag = r.tag;
        trk_seq = r.seq;
      end
      trk_last_from = r.from_st;
      trk_last_to = r.to_st;
      trk_last_tag = r.tag;
      trk_last_seq = r.seq;
      trk_count = trk_count + 16'd1;
      trk_state = r.to_st;
    end
    o.status = code;
    o.state = trk_state;
    o.visible = (trk_state == ST_PUBLISHED || trk_state == ST_ACCEPTED);
  endtask

  function automatic logic [TAG_W-1:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [TAG_W-1:0] pick_id();
    int r;
    r = $urandom_range(0, 99);
    if (r < 8) return '0;
    if (r < 16) return '1;
    return rand64();
  endfunction

  function automatic logic [TAG_W-1:0] flip_mask();
    logic [TAG_W-1:0] m;
    do m = rand64(); while (m == '0);
    return m;
  endfunction

  task automatic queue_item(input request_t r);
    request_q = {request_q, r};
    requests_queued++;
  endtask

  task automatic queue_fields(input logic op, input logic [TAG_W-1:0] view,
                              input logic [TAG_W-1:0] bound,
                              input logic [CODE_W-1:0] from_st,
                              input logic [CODE_W-1:0] to_st,
                              input logic [TAG_W-1:0] tag, input logic [SEQ_W-1:0] seq);
    request_t r;
    r.op = op;
    r.view = view;
    r.bound = bound;
    r.from_st = from_st;
    r.to_st = to_st;
    r.tag = tag;
    r.seq = seq;
    queue_item(r);
  endtask

  task automatic wait_drained();
    while (results_checked != requests_queued) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_register(input logic [CFG_INDEX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] value);
    @(posedge clk);
    cfg_wen <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_wen <= 1'b0;
    if (idx == CFG_BOUNDARY) boundary_reg = value;
    else limit_reg = value[COUNT_W-1:0];
  endtask

  // one well-formed step of the lifecycle with random content
  task automatic emit_step(input bit allow_terminal);
    request_t r;
    int pick;
    r.op = OP_TRANSITION;
    r.view = plan_view;
    r.bound = boundary_reg;
    r.from_st = plan_state;
    r.to_st = plan_state;
    r.tag = plan_tag;
    r.seq = plan_seq;
    if (!plan_present || plan_state == ST_ACCEPTED || plan_state == ST_FAIL_TERM) begin
      r.op = OP_INSTALL;
      r.view = pick_id();
      r.bound = rand64();
      r.from_st = CODE_W'($urandom_range(0, 7));
      r.to_st = CODE_W'($urandom_range(0, 7));
      r.tag = rand64();
      r.seq = $urandom;
      if (plan_state != ST_FAIL_TERM || !plan_present) begin
        plan_present = 1'b1;
        plan_view = r.view;
        plan_state = ST_NOT_PUB;
        plan_tag = '0;
        plan_seq = '0;
        plan_has_last = 1'b0;
      end
      queue_item(r);
    end else begin
      case (plan_state)
        ST_NOT_PUB, ST_FAIL_RETRY: begin
          r.to_st = ST_IN_PROG;
          r.seq = plan_seq + 32'd1;
          do r.tag = pick_id(); while (plan_state == ST_FAIL_RETRY && r.tag == plan_tag);
        end
        ST_IN_PROG: begin
          pick = $urandom_range(0, 99);
          if (pick < 50) r.to_st = ST_PUBLISHED;
          else if (pick < 85 || !allow_terminal) r.to_st = ST_FAIL_RETRY;
          else r.to_st = ST_FAIL_TERM;
        end
        default: r.to_st = ST_ACCEPTED;
      endcase
      plan_state = r.to_st;
      plan_tag = r.tag;
      plan_seq = r.seq;
      plan_last = r;
      plan_has_last = 1'b1;
      queue_item(r);
    end
  endtask

  // broken or refused requests around the planned state
  task automatic emit_noise();
    request_t r;
    r.op = OP_TRANSITION;
    r.view = plan_view;
    r.bound = boundary_reg;
    r.from_st = plan_state;
    r.to_st = CODE_W'($urandom_range(0, 7));
    r.tag = plan_tag;
    r.seq = plan_seq;
    case ($urandom_range(0, 7))
      0: begin
        if (plan_has_last) r = plan_last;
        else r.view = plan_view ^ flip_mask();
      end
      1: r.view = plan_view ^ flip_mask();
      2: r.bound = boundary_reg ^ flip_mask();
      3: begin
        r.from_st = CODE_W'($urandom_range(0, 7));
        r.tag = rand64();
        r.seq = $urandom;
      end
      4: begin
        r.to_st = (plan_state == ST_IN_PROG) ? ST_PUBLISHED : ST_IN_PROG;
        r.seq = plan_seq + SEQ_W'($urandom_range(2, 1000));
      end
      5: r.from_st = plan_state + CODE_W'($urandom_range(1, 7));
      6: begin
        if (plan_present && plan_state != ST_ACCEPTED) begin
          r.op = OP_INSTALL;
          r.view = ($urandom_range(0, 1) == 0) ? plan_view : rand64();
        end else begin
          r.view = plan_view ^ flip_mask();
        end
      end
      default: begin
        r.to_st = ST_IN_PROG;
        if (plan_state == ST_FAIL_RETRY) begin
          r.seq = plan_seq + 32'd1;
        end else begin
          r.seq = '1;
        end
      end
    endcase
    queue_item(r);
  endtask

  // request side
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        track_request(offered, predicted);
        outcome_q = {outcome_q, predicted};
      end
      if (!s_tvalid || s_tready) begin
        if (send_gap > 0) begin
          send_gap--;
          s_tvalid <= 1'b0;
        end else if (request_q.size() != 0) begin
          offered = request_q.pop_front();
          s_tvalid <= 1'b1;
          s_tdata <= {2'b00, offered.seq, offered.tag, offered.to_st, offered.from_st,
                      offered.bound, offered.view};
          s_tuser <= offered.op;
          if (!sender_idle_en || $urandom_range(0, 99) < 70) send_gap = 0;
          else if ($urandom_range(0, 99) < 80) send_gap = $urandom_range(1, 3);
          else send_gap = $urandom_range(8, 30);
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  task automatic check_field(input string name, input logic [CODE_W-1:0] exp_v,
                             input logic [CODE_W-1:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s expected %0d, got %0d", $time, name, exp_v, act_v);
      error_count++;
    end
  endtask

  // result side
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        got.status = m_tdata[2:0];
        got.state = m_tdata[5:3];
        got.visible = m_tdata[6];
        if (outcome_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, got 0x%0h", $time, m_tdata);
          error_count++;
        end else begin
          want = outcome_q.pop_front();
          results_checked++;
          check_field("status", want.status, got.status);
          check_field("state_out", want.state, got.state);
          check_field("view_visible", CODE_W'(want.visible), CODE_W'(got.visible));
        end
      end
      if (hold_served != hold_asked) begin
        hold_served = hold_asked;
        stall_left = LONG_HOLD;
      end
      if (stall_left > 0) begin
        stall_left--;
        m_tready <= 1'b0;
      end else if (receiver_idle_en && $urandom_range(0, 99) < 15) begin
        if ($urandom_range(0, 99) < 85) stall_left = $urandom_range(0, 2);
        else stall_left = $urandom_range(10, 30);
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  initial begin
    logic [TAG_W-1:0]   bval;
    logic [COUNT_W-1:0] lval;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    queue_fields(OP_TRANSITION, 64'd5, 64'd0, ST_NOT_PUB, ST_IN_PROG, 64'd1, 32'd1);
    queue_fields(OP_INSTALL, ONES, 64'd0, ST_NOT_PUB, ST_NOT_PUB, 64'd0, 32'd0);
    queue_fields(OP_INSTALL, ONES, ONES, 3'd7, 3'd7, ONES, '1);
    queue_fields(OP_TRANSITION, 64'd0, 64'd0, ST_NOT_PUB, ST_IN_PROG, 64'd1, 32'd1);
    queue_fields(OP_TRANSITION, ONES, ONES, ST_NOT_PUB, ST_IN_PROG, 64'd1, 32'd1);
    queue_fields(OP_TRANSITION, ONES, 64'd0, 3'd6, 3'd7, 64'd1, 32'd1);
    queue_fields(OP_TRANSITION, ONES, 64'd0, ST_NOT_PUB, ST_IN_PROG, 64'd7, '1);
    queue_fields(OP_TRANSITION, ONES, 64'd0, ST_NOT_PUB, ST_IN_PROG, ONES, 32'd1);
    queue_fields(OP_TRANSITION, ONES, 64'd0, ST_NOT_PUB, ST_IN_PROG, ONES, 32'd1);
    queue_fields(OP_TRANSITION, ONES, 64'd0, ST_IN_PROG, ST_FAIL_RETRY, 64'd0, 32'd1);
    queue_fields(OP_TRANSITION, ONES, 64'd0, ST_IN_PROG, ST_FAIL_RETRY, ONES, 32'd1);
    queue_fields(OP_TRANSITION, ONES, 64'd0, ST_FAIL_RETRY, ST_IN_PROG, ONES, 32'd2);
    queue_fields(OP_TRANSITION, ONES, 64'd0, ST_FAIL_RETRY, ST_IN_PROG, 64'd0, 32'd2);
    queue_fields(OP_TRANSITION, ONES, 64'd0, ST_IN_PROG, ST_PUBLISHED, 64'd0, 32'd2);
    queue_fields(OP_TRANSITION, ONES, 64'd0, ST_PUBLISHED, ST_ACCEPTED, 64'd0, 32'd2);
    queue_fields(OP_INSTALL, 64'd0, ONES, 3'd7, 3'd7, ONES, '1);
    wait_drained();
    write_register(CFG_HISTORY, 64'd0);
    queue_fields(OP_TRANSITION, 64'd0, 64'd0, ST_NOT_PUB, ST_IN_PROG, 64'd1, 32'd1);
    wait_drained();
    write_register(CFG_HISTORY, 64'd1);
    queue_fields(OP_TRANSITION, 64'd0, 64'd0, ST_NOT_PUB, ST_IN_PROG, 64'd1, 32'd1);
    queue_fields(OP_TRANSITION, 64'd0, 64'd0, ST_IN_PROG, ST_FAIL_TERM, 64'd1, 32'd1);
    queue_fields(OP_TRANSITION, 64'd0, 64'd0, ST_NOT_PUB, ST_IN_PROG, 64'd1, 32'd1);
    wait_drained();
    write_register(CFG_BOUNDARY, ONES);
    write_register(CFG_HISTORY, 64'hFFFF);
    queue_fields(OP_TRANSITION, 64'd0, ONES, ST_IN_PROG, ST_PUBLISHED, 64'd1, 32'd1);
    queue_fields(OP_TRANSITION, 64'd0, ONES, ST_PUBLISHED, ST_IN_PROG, 64'd1, 32'd1);
    queue_fields(OP_TRANSITION, 64'd0, ONES, ST_PUBLISHED, ST_ACCEPTED, 64'd1, 32'd1);

    for (int p = 0; p < PHASES; p++) begin
      wait_drained();
      case (p)
        1:       bval = '0;
        3:       bval = '1;
        default: bval = rand64();
      endcase
      case (p)
        1:       lval = 16'd3;
        2:       lval = 16'hFFFF;
        3:       lval = 16'd1;
        5:       lval = 16'd24;
        6:       lval = 16'hFFFF;
        7:       lval = 16'd2;
        9:       lval = 16'hFFFF;
        default: lval = HISTORY_RESET;
      endcase
      write_register(CFG_BOUNDARY, bval);
      write_register(CFG_HISTORY, CFG_DATA_W'(lval));

      plan_present = trk_present;
      plan_view = trk_view;
      plan_state = trk_state;
      plan_tag = trk_tag;
      plan_seq = trk_seq;
      plan_has_last = (trk_count != 0);
      plan_last.op = OP_TRANSITION;
      plan_last.view = trk_view;
      plan_last.bound = boundary_reg;
      plan_last.from_st = trk_last_from;
      plan_last.to_st = trk_last_to;
      plan_last.tag = trk_last_tag;
      plan_last.seq = trk_last_seq;

      sender_idle_en = (p != 2 && p != 4);
      receiver_idle_en = (p != 2);
      if (p == 4) hold_asked++;

      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (p == 6 && i == PHASE_ITEMS / 2) wait_drained();
        if ($urandom_range(0, 99) < 75) emit_step(p == PHASES - 1);
        else emit_noise();
      end
    end

    wait_drained();
    repeat (10) @(posedge clk);
    if (error_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #(5_000_000);
    $display("*** FAILED ***");
    $finish;
  end

endmodule
